>>> src/cbc_pkg.sv
package cbc_pkg;

   // fixed geometry of the cartridge bus
   localparam int ROM_BANK_BYTES = 16384;
   localparam int RAM_BANK_BYTES = 8192;
   localparam int ROM_OFF_W      = $clog2(ROM_BANK_BYTES);
   localparam int RAM_OFF_W      = $clog2(RAM_BANK_BYTES);
   localparam int ROM_BANK_W     = 7;
   localparam int RAM_BANK_W     = 2;
   localparam int RAM_IDX_W      = RAM_BANK_W + RAM_OFF_W;
   localparam int ROM_ADDR_W     = ROM_BANK_W + ROM_OFF_W;

   // defaults for top-level parameters
   localparam int RAM_BYTES_DEF  = 32768;
   localparam int CMD_DEPTH_DEF  = 4;
   localparam int RSP_DEPTH_DEF  = 4;

   // field widths
   localparam int FUNC_W       = 2;
   localparam int ADDR_W       = 16;
   localparam int DATA_W       = 8;
   localparam int STATUS_W     = 2;
   localparam int ROM_SIZE_W   = 22;
   localparam int RAM_SIZE_W   = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_SIZE = 2'd1;

   localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RST = 22'd2097152;
   localparam logic [RAM_SIZE_W-1:0] RAM_SIZE_RST = 16'd32768;

   // bus functions
   localparam logic [FUNC_W-1:0] FN_READ  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_TICK  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ROM  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

   // 8 KiB address regions, selected by address[15:13]
   localparam logic [2:0] RGN_ROM_BANK = 3'd1;
   localparam logic [2:0] RGN_BANK_SEL = 3'd2;
   localparam logic [2:0] RGN_LATCH    = 3'd3;
   localparam logic [2:0] RGN_RAM      = 3'd5;

   // bank select values
   localparam logic [DATA_W-1:0] SEL_RAM_MAX = 8'h03;
   localparam logic [DATA_W-1:0] SEL_RTC_MIN = 8'h08;
   localparam logic [DATA_W-1:0] SEL_RTC_MAX = 8'h0C;

   // RTC register selects (register minus 0x08)
   localparam logic [2:0] RTC_SEC  = 3'd0;
   localparam logic [2:0] RTC_MIN  = 3'd1;
   localparam logic [2:0] RTC_HOUR = 3'd2;

   localparam logic [5:0] LAST_SEC_MIN = 6'd59;
   localparam logic [DATA_W-1:0] BYTE_FF = 8'hFF;

   // command kinds handed from front to back
   localparam logic [1:0] CMD_DONE = 2'd0;
   localparam logic [1:0] CMD_RD   = 2'd1;
   localparam logic [1:0] CMD_WR   = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [DATA_W-1:0]     read_data;
      logic [ROM_ADDR_W-1:0] rom_address;
   } rsp_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [RAM_IDX_W-1:0] idx;
      logic [DATA_W-1:0]    data;
      rsp_type              rsp;
   } cmd_type;

endpackage

>>> src/cartridge_bank_controller_rtc_top.sv
// An accepted beat passes the command queue, the RAM read register and the result queue.
// Throughput: one beat per cycle, set by the single-port RAM, while the rsp queue has room.
// The command and result queues let the input keep accepting while results wait.
// Reset: synchronous, active high; returns bank, mode, clock and size registers to defaults.
// After reset the RAM is swept to zero, address by address; req_full stays high meanwhile.
module cartridge_bank_controller_rtc_top #(
   parameter int RAM_BYTES = cbc_pkg::RAM_BYTES_DEF,
   parameter int CMD_DEPTH = cbc_pkg::CMD_DEPTH_DEF,
   parameter int RSP_DEPTH = cbc_pkg::RSP_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [cbc_pkg::FUNC_W-1:0]         req_func,
   input  logic [cbc_pkg::ADDR_W-1:0]         req_address,
   input  logic [cbc_pkg::DATA_W-1:0]         req_write_data,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [cbc_pkg::STATUS_W-1:0]       rsp_status,
   output logic [cbc_pkg::DATA_W-1:0]         rsp_read_data,
   output logic [cbc_pkg::ROM_ADDR_W-1:0]     rsp_rom_address,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cbc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   import cbc_pkg::*;

   cmd_type                        cmd_in;
   cmd_type                        cmd_out;
   logic                           cmd_push;
   logic                           cmd_pop;
   logic                           cmd_full;
   logic                           cmd_empty;
   logic                           clearing;
   rsp_type                        rsp_in;
   rsp_type                        rsp_out;
   logic                           rsp_push;
   logic                           rsp_full;
   logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count;

   cbc_front #(
      .RAM_BYTES (RAM_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd_full       (cmd_full),
      .clearing       (clearing),
      .cmd_push       (cmd_push),
      .cmd            (cmd_in)
   );

   cbc_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_in),
      .pop   (cmd_pop),
      .dout  (cmd_out),
      .full  (cmd_full),
      .empty (cmd_empty),
      .count ()
   );

   cbc_back #(
      .RAM_BYTES (RAM_BYTES),
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_out),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .clearing  (clearing),
      .rsp_count (rsp_count),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   cbc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_in),
      .pop   (rsp_pop),
      .dout  (rsp_out),
      .full  (rsp_full),
      .empty (rsp_empty),
      .count (rsp_count)
   );

   assign rsp_status      = rsp_out.status;
   assign rsp_read_data   = rsp_out.read_data;
   assign rsp_rom_address = rsp_out.rom_address;

endmodule

>>> src/cbc_ram.sv
module cbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/cbc_fifo.sv
module cbc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           din,
   input  logic                       pop,
   output logic [WIDTH-1:0]           dout,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign dout    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

>>> src/cbc_front.sv
module cbc_front #(
   parameter int RAM_BYTES = cbc_pkg::RAM_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [cbc_pkg::FUNC_W-1:0]      req_func,
   input  logic [cbc_pkg::ADDR_W-1:0]      req_address,
   input  logic [cbc_pkg::DATA_W-1:0]      req_write_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cbc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cbc_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            cmd_full,
   input  logic                            clearing,
   output logic                            cmd_push,
   output cbc_pkg::cmd_type                cmd
);

   import cbc_pkg::*;

   logic [ROM_SIZE_W-1:0] rom_size_ff, rom_size_in;
   logic [RAM_SIZE_W-1:0] ram_size_ff, ram_size_in;
   logic [ROM_BANK_W-1:0] rom_bank_ff, rom_bank_in;
   logic [RAM_BANK_W-1:0] ram_bank_ff, ram_bank_in;
   logic                  rtc_mode_ff, rtc_mode_in;
   logic [2:0]            rtc_select_ff, rtc_select_in;
   logic                  last_zero_ff, last_zero_in;
   logic [31:0]           elapsed_ff, elapsed_in;
   logic [5:0]            sec_ff, sec_in;
   logic [5:0]            min_ff, min_in;
   logic [7:0]            hour_ff, hour_in;
   logic [5:0]            lsec_ff, lsec_in;
   logic [5:0]            lmin_ff, lmin_in;
   logic [7:0]            lhour_ff, lhour_in;

   logic                  accept;
   logic                  csr_wr;
   logic [2:0]            region;
   logic [ROM_ADDR_W-1:0] rom_off;
   logic [RAM_IDX_W-1:0]  ram_idx;
   logic                  ram_ok;
   logic [DATA_W-1:0]     rtc_byte;
   logic [ROM_BANK_W-1:0] bank_req;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign req_full  = cmd_full || clearing;
   assign accept    = req_push && !req_full;
   assign cmd_push  = accept;

   assign region   = req_address[ADDR_W-1:ADDR_W-3];
   assign rom_off  = {rom_bank_ff, req_address[ROM_OFF_W-1:0]};
   assign ram_idx  = {ram_bank_ff, req_address[RAM_OFF_W-1:0]};
   assign ram_ok   = ({1'b0, ram_idx} < ram_size_ff) && (32'(ram_idx) < RAM_BYTES);
   assign bank_req = req_write_data[ROM_BANK_W-1:0];

   // pick the latched RTC register
   always_comb begin
      unique case (rtc_select_ff)
         RTC_SEC:  rtc_byte = {2'b00, lsec_ff};
         RTC_MIN:  rtc_byte = {2'b00, lmin_ff};
         RTC_HOUR: rtc_byte = lhour_ff;
         default:  rtc_byte = '0;
      endcase
   end

   // classify the beat, update bank and clock state, and take CSR writes
   always_comb begin
      rom_size_in   = rom_size_ff;
      ram_size_in   = ram_size_ff;
      rom_bank_in   = rom_bank_ff;
      ram_bank_in   = ram_bank_ff;
      rtc_mode_in   = rtc_mode_ff;
      rtc_select_in = rtc_select_ff;
      last_zero_in  = last_zero_ff;
      elapsed_in    = elapsed_ff;
      sec_in        = sec_ff;
      min_in        = min_ff;
      hour_in       = hour_ff;
      lsec_in       = lsec_ff;
      lmin_in       = lmin_ff;
      lhour_in      = lhour_ff;

      cmd.kind            = CMD_DONE;
      cmd.idx             = ram_idx;
      cmd.data            = req_write_data;
      cmd.rsp.status      = ST_DONE;
      cmd.rsp.read_data   = '0;
      cmd.rsp.rom_address = '0;

      if (csr_wr) begin
         if (csr_index == CSR_ROM_SIZE) begin
            rom_size_in = csr_write_data[ROM_SIZE_W-1:0];
         end else if (csr_index == CSR_RAM_SIZE) begin
            ram_size_in = csr_write_data[RAM_SIZE_W-1:0];
         end
      end

      if (req_func == FN_READ) begin
         if (req_address[ADDR_W-1:ROM_OFF_W] == '0) begin
            if ({6'b0, req_address} < rom_size_ff) begin
               cmd.rsp.status      = ST_ROM;
               cmd.rsp.rom_address = ROM_ADDR_W'(req_address);
            end else begin
               cmd.rsp.read_data = BYTE_FF;
            end
         end else if (!req_address[ADDR_W-1]) begin
            if ({1'b0, rom_off} < rom_size_ff) begin
               cmd.rsp.status      = ST_ROM;
               cmd.rsp.rom_address = rom_off;
            end else begin
               cmd.rsp.read_data = BYTE_FF;
            end
         end else if (region == RGN_RAM) begin
            if (rtc_mode_ff) begin
               cmd.rsp.read_data = rtc_byte;
            end else if (ram_ok) begin
               cmd.kind = CMD_RD;
            end else begin
               cmd.rsp.read_data = BYTE_FF;
            end
         end else begin
            cmd.rsp.status = ST_BAD;
         end
      end else if (req_func == FN_WRITE) begin
         if (region == RGN_ROM_BANK) begin
            rom_bank_in = (bank_req == '0) ? ROM_BANK_W'(1) : bank_req;
         end else if (region == RGN_BANK_SEL) begin
            if (req_write_data <= SEL_RAM_MAX) begin
               ram_bank_in = req_write_data[RAM_BANK_W-1:0];
               rtc_mode_in = 1'b0;
            end else if (req_write_data >= SEL_RTC_MIN && req_write_data <= SEL_RTC_MAX) begin
               rtc_select_in = 3'(req_write_data - SEL_RTC_MIN);
               rtc_mode_in   = 1'b1;
            end
         end else if (region == RGN_LATCH) begin
            if (last_zero_ff && req_write_data == 8'd1) begin
               lsec_in  = sec_ff;
               lmin_in  = min_ff;
               lhour_in = hour_ff;
            end
            last_zero_in = (req_write_data == '0);
         end else if (region == RGN_RAM) begin
            if (!rtc_mode_ff && ram_ok) begin
               cmd.kind = CMD_WR;
            end
         end
      end else if (req_func == FN_TICK) begin
         // count seconds; a wrap of the 32-bit count restarts seconds, minutes and hours
         if (elapsed_ff == '1) begin
            elapsed_in = '0;
            sec_in     = '0;
            min_in     = '0;
            hour_in    = '0;
         end else begin
            elapsed_in = elapsed_ff + 1'b1;
            if (sec_ff == LAST_SEC_MIN) begin
               sec_in = '0;
               if (min_ff == LAST_SEC_MIN) begin
                  min_in  = '0;
                  hour_in = hour_ff + 1'b1;
               end else begin
                  min_in = min_ff + 1'b1;
               end
            end else begin
               sec_in = sec_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_size_ff <= ROM_SIZE_RST;
         ram_size_ff <= RAM_SIZE_RST;
      end else begin
         rom_size_ff <= rom_size_in;
         ram_size_ff <= ram_size_in;
      end
   end

   // bank and clock state moves only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff   <= ROM_BANK_W'(1);
         ram_bank_ff   <= '0;
         rtc_mode_ff   <= 1'b0;
         rtc_select_ff <= RTC_SEC;
         last_zero_ff  <= 1'b0;
         elapsed_ff    <= '0;
         sec_ff        <= '0;
         min_ff        <= '0;
         hour_ff       <= '0;
         lsec_ff       <= '0;
         lmin_ff       <= '0;
         lhour_ff      <= '0;
      end else if (accept) begin
         rom_bank_ff   <= rom_bank_in;
         ram_bank_ff   <= ram_bank_in;
         rtc_mode_ff   <= rtc_mode_in;
         rtc_select_ff <= rtc_select_in;
         last_zero_ff  <= last_zero_in;
         elapsed_ff    <= elapsed_in;
         sec_ff        <= sec_in;
         min_ff        <= min_in;
         hour_ff       <= hour_in;
         lsec_ff       <= lsec_in;
         lmin_ff       <= lmin_in;
         lhour_ff      <= lhour_in;
      end
   end

   a_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      rom_bank_ff != '0) else $error("ROM bank register holds zero");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      sec_ff <= LAST_SEC_MIN && min_ff <= LAST_SEC_MIN)
      else $error("RTC seconds or minutes out of range");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !cmd_push) else $error("beat accepted during RAM clear");

endmodule

>>> src/cbc_back.sv
module cbc_back #(
   parameter int RAM_BYTES = cbc_pkg::RAM_BYTES_DEF,
   parameter int RSP_DEPTH = cbc_pkg::RSP_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cbc_pkg::cmd_type                   cmd,
   input  logic                               cmd_empty,
   output logic                               cmd_pop,
   output logic                               clearing,
   input  logic [$clog2(RSP_DEPTH+1)-1:0]     rsp_count,
   input  logic                               rsp_full,
   output logic                               rsp_push,
   output cbc_pkg::rsp_type                   rsp
);

   import cbc_pkg::*;

   localparam int AW = $clog2(RAM_BYTES);
   localparam int CW = $clog2(RSP_DEPTH+1);

   logic          clear_ff, clear_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          pipe_v_ff, pipe_v_in;
   logic          pipe_rd_ff;
   rsp_type       pipe_rsp_ff;

   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;
   logic              issue;

   assign clearing = clear_ff;

   // issue only when the result queue has room for the beat in flight too
   assign issue   = !clear_ff && !cmd_empty &&
                    ({1'b0, rsp_count} + (CW+1)'(pipe_v_ff) < (CW+1)'(RSP_DEPTH));
   assign cmd_pop = issue;

   assign ram_we    = clear_ff || (issue && cmd.kind == CMD_WR);
   assign ram_addr  = clear_ff ? clr_cnt_ff : cmd.idx[AW-1:0];
   assign ram_wdata = clear_ff ? '0 : cmd.data;

   cbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RAM_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // sweep the RAM to zero after reset
   always_comb begin
      clear_in   = clear_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clear_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(RAM_BYTES-1)) begin
            clear_in = 1'b0;
         end
      end
   end

   assign pipe_v_in = issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_cnt_ff <= '0;
         pipe_v_ff  <= 1'b0;
      end else begin
         clear_ff   <= clear_in;
         clr_cnt_ff <= clr_cnt_in;
         pipe_v_ff  <= pipe_v_in;
      end
   end

   // hold the result fields while the RAM read completes
   always_ff @(posedge clock) begin
      if (issue) begin
         pipe_rd_ff  <= (cmd.kind == CMD_RD);
         pipe_rsp_ff <= cmd.rsp;
      end
   end

   // merge RAM data into the result beat
   always_comb begin
      rsp = pipe_rsp_ff;
      if (pipe_rd_ff) begin
         rsp.read_data = ram_rdata;
      end
   end

   assign rsp_push = pipe_v_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pipe_v_ff |-> !rsp_full) else $error("result queue overflow");

   a_no_issue_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !cmd_pop) else $error("command issued during RAM clear");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |-> $past(clr_cnt_ff) == AW'(RAM_BYTES-1))
      else $error("RAM clear ended early");

endmodule
